[sv/bwspt_pkg.sv]
package bwspt_pkg;

  localparam int WAIT_W   = 10;
  localparam int CREDIT_W = 12;
  localparam int SUM_W    = 14;

  typedef enum logic [2:0] {
    OP_DATA16_N = 3'd0,
    OP_DATA32_N = 3'd1,
    OP_DATA32_S = 3'd2,
    OP_CODE16_N = 3'd3,
    OP_CODE32_N = 3'd4,
    OP_CODE16_S = 3'd5,
    OP_CODE32_S = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    CFG_SAVE_WAIT   = 3'd0,
    CFG_ROM0_NONSEQ = 3'd1,
    CFG_ROM0_SEQ    = 3'd2,
    CFG_ROM1_NONSEQ = 3'd3,
    CFG_ROM1_SEQ    = 3'd4,
    CFG_ROM2_NONSEQ = 3'd5,
    CFG_ROM2_SEQ    = 3'd6,
    CFG_PF_ENABLE   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0] save_wait;
    logic [3:0] rom0_n;
    logic [3:0] rom0_s;
    logic [3:0] rom1_n;
    logic [3:0] rom1_s;
    logic [3:0] rom2_n;
    logic [3:0] rom2_s;
    logic       pf_en;
  } cfg_t;

  typedef struct packed {
    logic [3:0] n16;
    logic [3:0] s16;
    logic [4:0] n32;
    logic [4:0] s32;
  } wait_set_t;

  localparam cfg_t CFG_RESET = '{
    save_wait: 4'd4, rom0_n: 4'd4, rom0_s: 4'd2, rom1_n: 4'd4, rom1_s: 4'd4,
    rom2_n: 4'd4, rom2_s: 4'd8, pf_en: 1'b0
  };

  localparam logic [31:0] STALL_LIMIT_ADDR = 32'h0601_0000;
  localparam logic [10:0] STALL_CYCLE      = 11'd980;
  localparam logic [2:0]  STALL_MODE_LIMIT = 3'd3;
  localparam logic [3:0]  VRAM_REGION      = 4'h6;
  localparam logic [3:0]  CART_FIRST       = 4'h8;
  localparam logic [3:0]  CART_LAST        = 4'hD;
  localparam logic [3:0]  ROM1_FIRST       = 4'hA;
  localparam logic [3:0]  ROM2_FIRST       = 4'hC;
  localparam logic [3:0]  SAVE_REGION      = 4'hE;
  localparam logic [3:0]  OPEN_REGION      = 4'hF;
  localparam logic [3:0]  EWRAM_REGION     = 4'h2;
  localparam logic [3:0]  PAL_REGION       = 4'h5;
  localparam logic signed [SUM_W-1:0] CREDIT_MIN = -14'sd2048;

  function automatic logic [3:0] fixed_n16(input logic [3:0] region);
    fixed_n16 = (region == EWRAM_REGION) ? 4'd2 : 4'd0;
  endfunction

  function automatic logic [4:0] fixed_n32(input logic [3:0] region);
    logic [4:0] w;
    w = 5'd0;
    if (region == EWRAM_REGION) begin
      w = 5'd5;
    end else if (region == PAL_REGION || region == VRAM_REGION) begin
      w = 5'd1;
    end
    fixed_n32 = w;
  endfunction

endpackage

[sv/bwspt_cfg_regs.sv]
module bwspt_cfg_regs
  import bwspt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [3:0] wr_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_SAVE_WAIT:   cfg_nxt.save_wait = wr_data;
        CFG_ROM0_NONSEQ: cfg_nxt.rom0_n    = wr_data;
        CFG_ROM0_SEQ:    cfg_nxt.rom0_s    = wr_data;
        CFG_ROM1_NONSEQ: cfg_nxt.rom1_n    = wr_data;
        CFG_ROM1_SEQ:    cfg_nxt.rom1_s    = wr_data;
        CFG_ROM2_NONSEQ: cfg_nxt.rom2_n    = wr_data;
        CFG_ROM2_SEQ:    cfg_nxt.rom2_s    = wr_data;
        CFG_PF_ENABLE:   cfg_nxt.pf_en     = wr_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/bwspt_wait_table.sv]
module bwspt_wait_table
  import bwspt_pkg::*;
(
  input  cfg_t       cfg,
  input  logic [3:0] region,
  output wait_set_t  waits
);

  logic [3:0] n;
  logic [3:0] s;

  always_comb begin
    if (region >= ROM2_FIRST) begin
      n = cfg.rom2_n;
      s = cfg.rom2_s;
    end else if (region >= ROM1_FIRST) begin
      n = cfg.rom1_n;
      s = cfg.rom1_s;
    end else begin
      n = cfg.rom0_n;
      s = cfg.rom0_s;
    end
    if (region == SAVE_REGION) begin
      n = cfg.save_wait;
      s = cfg.save_wait;
    end

    if (region < CART_FIRST || region == OPEN_REGION) begin
      waits.n16 = fixed_n16(region);
      waits.s16 = fixed_n16(region);
      waits.n32 = fixed_n32(region);
      waits.s32 = fixed_n32(region);
    end else begin
      waits.n16 = n;
      waits.s16 = s;
      waits.n32 = 5'(n) + 5'(s) + 5'd1;
      waits.s32 = {s, 1'b1};
    end
  end

endmodule

[sv/bwspt_credit.sv]
module bwspt_credit
  import bwspt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              pf_en,
  input  logic [2:0]        operation,
  input  logic [31:0]       address,
  input  logic [7:0]        extra_cycles,
  input  logic              line_visible,
  input  logic [10:0]       line_cycle,
  input  logic [2:0]        bg_mode,
  input  wait_set_t         acc_waits,
  input  wait_set_t         pc_waits,
  output logic [WAIT_W-1:0] wait_ticks
);

  logic signed [CREDIT_W-1:0] credit_r;
  logic signed [CREDIT_W-1:0] credit_nxt;

  logic [3:0]              region;
  logic [4:0]              base_wait;
  logic                    is_data;
  logic                    is_code;
  logic                    stall;
  logic [WAIT_W-1:0]       stall_add;
  logic [WAIT_W-1:0]       data_wait;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] cap;
  logic signed [SUM_W-1:0] clamped;
  logic                    in_cart;
  logic                    cred_pos;
  logic [4:0]              sub;

  assign region = address[27:24];

  always_comb begin
    base_wait = 5'd0;
    is_data   = 1'b0;
    is_code   = 1'b0;
    unique case (op_t'(operation))
      OP_DATA16_N: begin base_wait = 5'(acc_waits.n16); is_data = 1'b1; end
      OP_DATA32_N: begin base_wait = acc_waits.n32;     is_data = 1'b1; end
      OP_DATA32_S: begin base_wait = acc_waits.s32;     is_data = 1'b1; end
      OP_CODE16_N: begin base_wait = 5'(acc_waits.n16); is_code = 1'b1; end
      OP_CODE32_N: begin base_wait = acc_waits.n32;     is_code = 1'b1; end
      OP_CODE16_S: begin base_wait = 5'(acc_waits.s16); is_code = 1'b1; end
      OP_CODE32_S: begin base_wait = acc_waits.s32;     is_code = 1'b1; end
      default:     base_wait = 5'd0;
    endcase
  end

  assign stall = (op_t'(operation) == OP_DATA32_N) && (region == VRAM_REGION) &&
                 line_visible && (address < STALL_LIMIT_ADDR) &&
                 (line_cycle < STALL_CYCLE) && (bg_mode < STALL_MODE_LIMIT);
  assign stall_add = WAIT_W'(STALL_CYCLE - line_cycle);
  assign data_wait = WAIT_W'(base_wait) + (stall ? stall_add : '0);

  // credit build on data items
  assign sum = SUM_W'(credit_r) + SUM_W'(data_wait) + SUM_W'(pc_waits.n16)
             - SUM_W'(pc_waits.s16) - SUM_W'(1) + SUM_W'(extra_cycles);
  assign cap = SUM_W'({pc_waits.s16, 3'b000});

  always_comb begin
    if (sum > cap) begin
      clamped = cap;
    end else if (sum < CREDIT_MIN) begin
      clamped = CREDIT_MIN;
    end else begin
      clamped = sum;
    end
  end

  // credit spend on cartridge code items
  assign in_cart  = (region >= CART_FIRST) && (region <= CART_LAST);
  assign cred_pos = (credit_r > 0);
  assign sub = (credit_r[CREDIT_W-1:5] == '0 && credit_r[4:0] < base_wait) ?
               credit_r[4:0] : base_wait;

  always_comb begin
    credit_nxt = credit_r;
    wait_ticks = '0;
    if (is_data) begin
      wait_ticks = data_wait;
      if (region >= CART_FIRST) begin
        credit_nxt = '0;
      end else if (pf_en) begin
        credit_nxt = CREDIT_W'(clamped);
      end
    end else if (is_code) begin
      if (in_cart && cred_pos) begin
        wait_ticks = WAIT_W'(base_wait - sub);
        credit_nxt = credit_r - CREDIT_W'(sub);
      end else begin
        wait_ticks = WAIT_W'(base_wait);
        if (op_t'(operation) != OP_CODE32_S) begin
          credit_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else if (advance) begin
      credit_r <= credit_nxt;
    end
  end

endmodule

[sv/bus_wait_state_prefetch_timer.sv]
// Bus wait-state timer with prefetch credit. Each item on the input stream
// is one bus access and yields exactly one result item carrying the wait
// ticks for that access. An item is registered in stage 1 on accept, and its
// result is computed from stage 1 and registered in the output register when
// stage 1 advances; one item per cycle is sustained while the output does not
// stall, with the prefetch credit register, which every item reads and writes,
// updated as each item leaves stage 1. Output stalls back up through the two
// stages. Configuration writes take effect on the next cycle and belong only
// in idle periods.
module bus_wait_state_prefetch_timer
  import bwspt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[2:0], address[34:3], pc_region[38:35], extra_cycles[46:39],
  // line_visible[47], line_cycle[58:48], bg_mode[61:59], zero[63:62]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // wait_ticks[9:0], zero[15:10]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  cfg_t              cfg;
  logic              s1_valid_r;
  logic [61:0]       s1_data_r;
  logic              out_valid_r;
  logic [WAIT_W-1:0] wait_r;
  logic              s1_adv;
  wait_set_t         acc_waits;
  wait_set_t         pc_waits;
  logic [WAIT_W-1:0] wait_ticks;

  assign cfg_ready = 1'b1;

  bwspt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata[61:0];
    end
  end

  bwspt_wait_table u_acc_table (
    .cfg    (cfg),
    .region (s1_data_r[30:27]),
    .waits  (acc_waits)
  );

  bwspt_wait_table u_pc_table (
    .cfg    (cfg),
    .region (s1_data_r[38:35]),
    .waits  (pc_waits)
  );

  bwspt_credit u_credit (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (s1_adv),
    .pf_en        (cfg.pf_en),
    .operation    (s1_data_r[2:0]),
    .address      (s1_data_r[34:3]),
    .extra_cycles (s1_data_r[46:39]),
    .line_visible (s1_data_r[47]),
    .line_cycle   (s1_data_r[58:48]),
    .bg_mode      (s1_data_r[61:59]),
    .acc_waits    (acc_waits),
    .pc_waits     (pc_waits),
    .wait_ticks   (wait_ticks)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      wait_r <= wait_ticks;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, wait_r};

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bwspt_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CREDIT_CAP_MUL = 8;
  localparam int CREDIT_FLOOR   = CREDIT_MIN;
  localparam logic [2:0] OP_UNDEF = 3'd7;

  typedef enum {WK_N16, WK_S16, WK_N32, WK_S32} wait_kind_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [3:0]  pc_region;
    logic [7:0]  extra;
    logic        visible;
    logic [10:0] line_cycle;
    logic [2:0]  bg_mode;
  } access_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // operation, address, pc_region, extra_cycles, line_visible, line_cycle, bg_mode, zero
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // wait_ticks, zero
  logic [15:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [3:0]  cfg_data   = '0;

  cfg_t        model_cfg;
  int          model_credit;
  logic [9:0]  expected_waits[$];

  int errors;
  int items_sent;
  int results_checked;
  int cfg_writes;
  int stall_hits;
  int credit_spends;
  int floor_hits;
  int burst_left;
  int rx_tick;
  int rx_mode;

  bus_wait_state_prefetch_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int region_wait(input logic [3:0] region, input wait_kind_t kind);
    int n;
    int s;
    bit wide;
    wide = (kind == WK_N32 || kind == WK_S32);
    if (region < CART_FIRST || region == OPEN_REGION) begin
      if (region == EWRAM_REGION) return wide ? 5 : 2;
      if (region == PAL_REGION || region == VRAM_REGION) return wide ? 1 : 0;
      return 0;
    end
    if (region < ROM1_FIRST) begin
      n = model_cfg.rom0_n;
      s = model_cfg.rom0_s;
    end else if (region < ROM2_FIRST) begin
      n = model_cfg.rom1_n;
      s = model_cfg.rom1_s;
    end else if (region <= CART_LAST) begin
      n = model_cfg.rom2_n;
      s = model_cfg.rom2_s;
    end else begin
      n = model_cfg.save_wait;
      s = model_cfg.save_wait;
    end
    case (kind)
      WK_N16:  return n;
      WK_S16:  return s;
      WK_N32:  return n + s + 1;
      default: return 2 * s + 1;
    endcase
  endfunction

  // wait ticks of one access; advances the prefetch credit
  function automatic logic [9:0] charge_access(input access_t a);
    logic [3:0] region;
    int w;
    int n_pc;
    int s_pc;
    int sum;
    int spend;
    region = a.addr[27:24];
    w = 0;
    if (a.op == OP_DATA16_N || a.op == OP_DATA32_N || a.op == OP_DATA32_S) begin
      case (a.op)
        OP_DATA16_N: w = region_wait(region, WK_N16);
        OP_DATA32_N: w = region_wait(region, WK_N32);
        default:     w = region_wait(region, WK_S32);
      endcase
      if (a.op == OP_DATA32_N && region == VRAM_REGION && a.visible &&
          a.addr < STALL_LIMIT_ADDR && a.line_cycle < STALL_CYCLE &&
          a.bg_mode < STALL_MODE_LIMIT) begin
        w += int'(STALL_CYCLE) - int'(a.line_cycle);
        stall_hits++;
      end
      if (region >= CART_FIRST) begin
        model_credit = 0;
      end else if (model_cfg.pf_en) begin
        s_pc = region_wait(a.pc_region, WK_S16);
        n_pc = region_wait(a.pc_region, WK_N16);
        sum = model_credit + w + n_pc - s_pc - 1 + int'(a.extra);
        if (sum > CREDIT_CAP_MUL * s_pc) sum = CREDIT_CAP_MUL * s_pc;
        if (sum < CREDIT_FLOOR) begin
          sum = CREDIT_FLOOR;
          floor_hits++;
        end
        model_credit = sum;
      end
    end else if (a.op != OP_UNDEF) begin
      case (a.op)
        OP_CODE16_N: w = region_wait(region, WK_N16);
        OP_CODE32_N: w = region_wait(region, WK_N32);
        OP_CODE16_S: w = region_wait(region, WK_S16);
        default:     w = region_wait(region, WK_S32);
      endcase
      if (region >= CART_FIRST && region <= CART_LAST && model_credit > 0) begin
        spend = (model_credit < w) ? model_credit : w;
        model_credit -= spend;
        w -= spend;
        credit_spends++;
      end else if (a.op != OP_CODE32_S) begin
        model_credit = 0;
      end
    end
    return w[9:0];
  endfunction

  function automatic access_t bus_access(input logic [2:0] op, input logic [31:0] addr,
                                         input logic [3:0] pc_region, input logic [7:0] extra,
                                         input logic visible, input logic [10:0] line_cycle,
                                         input logic [2:0] bg_mode);
    access_t a;
    a.op = op;
    a.addr = addr;
    a.pc_region = pc_region;
    a.extra = extra;
    a.visible = visible;
    a.line_cycle = line_cycle;
    a.bg_mode = bg_mode;
    return a;
  endfunction

  function automatic access_t random_access();
    access_t a;
    a.op = 3'($urandom_range(0, 7));
    a.addr = $urandom;
    if ($urandom_range(0, 3) != 0) a.addr[31:28] = 4'h0;
    a.pc_region = 4'($urandom_range(0, 15));
    a.extra = 8'($urandom_range(0, 255));
    a.visible = 1'($urandom_range(0, 1));
    a.line_cycle = 11'($urandom_range(0, 2047));
    a.bg_mode = 3'($urandom_range(0, 7));
    return a;
  endfunction

  task automatic send_access(input access_t a);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {2'b00, a.bg_mode, a.line_cycle, a.visible, a.extra, a.pc_region, a.addr, a.op};
    do @(posedge clk); while (!in_tready);
    expected_waits.push_back(charge_access(a));
    items_sent++;
  endtask

  // stop the input and wait until every result is back
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_waits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [3:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SAVE_WAIT:   model_cfg.save_wait = value;
      CFG_ROM0_NONSEQ: model_cfg.rom0_n = value;
      CFG_ROM0_SEQ:    model_cfg.rom0_s = value;
      CFG_ROM1_NONSEQ: model_cfg.rom1_n = value;
      CFG_ROM1_SEQ:    model_cfg.rom1_s = value;
      CFG_ROM2_NONSEQ: model_cfg.rom2_n = value;
      CFG_ROM2_SEQ:    model_cfg.rom2_s = value;
      default:         model_cfg.pf_en = value[0];
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input cfg_t c);
    drain();
    write_reg(CFG_SAVE_WAIT, c.save_wait);
    write_reg(CFG_ROM0_NONSEQ, c.rom0_n);
    write_reg(CFG_ROM0_SEQ, c.rom0_s);
    write_reg(CFG_ROM1_NONSEQ, c.rom1_n);
    write_reg(CFG_ROM1_SEQ, c.rom1_s);
    write_reg(CFG_ROM2_NONSEQ, c.rom2_n);
    write_reg(CFG_ROM2_SEQ, c.rom2_s);
    write_reg(CFG_PF_ENABLE, {3'b000, c.pf_en});
  endtask

  task automatic test_fixed_regions();
    send_access(bus_access(OP_DATA16_N, 32'h0200_0000, 4'h0, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_DATA32_N, 32'h02FF_FFFF, 4'h0, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_DATA32_S, 32'h0500_0000, 4'h0, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_CODE16_N, 32'h0800_0000, 4'h8, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_CODE32_N, 32'h0A00_1234, 4'hA, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_CODE16_S, 32'h0C00_0000, 4'hC, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_CODE32_S, 32'h0DFF_FFFE, 4'hD, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_DATA16_N, 32'h0E00_0000, 4'h0, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_DATA32_S, 32'hFF00_0000, 4'hF, 8'hFF, 1'b1, 11'h7FF, 3'h7));
    send_access(bus_access(OP_UNDEF, 32'hFFFF_FFFF, 4'hF, 8'hFF, 1'b1, 11'h7FF, 3'h7));
  endtask

  task automatic test_video_stall();
    send_access(bus_access(OP_DATA32_N, 32'h0600_0000, 4'h0, 8'h00, 1'b1, 11'd0, 3'd0));
    send_access(bus_access(OP_DATA32_N, 32'h0600_FFFF, 4'h0, 8'h00, 1'b1, 11'd979, 3'd2));
    send_access(bus_access(OP_DATA32_N, 32'h0600_0000, 4'h0, 8'h00, 1'b1, 11'd980, 3'd0));
    send_access(bus_access(OP_DATA32_N, 32'h0601_0000, 4'h0, 8'h00, 1'b1, 11'd0, 3'd0));
    send_access(bus_access(OP_DATA32_N, 32'h0600_0000, 4'h0, 8'h00, 1'b1, 11'd0, 3'd3));
    send_access(bus_access(OP_DATA32_N, 32'h0600_0000, 4'h0, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_DATA32_S, 32'h0600_0000, 4'h0, 8'h00, 1'b1, 11'd0, 3'd0));
    send_access(bus_access(OP_DATA32_N, 32'h1600_0000, 4'h0, 8'h00, 1'b1, 11'd0, 3'd0));
  endtask

  task automatic test_prefetch_credit();
    drain();
    write_reg(CFG_PF_ENABLE, 4'd1);
    // fill to the cap, then spend it on cartridge fetches
    send_access(bus_access(OP_DATA16_N, 32'h0300_0000, 4'h8, 8'hFF, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_CODE16_S, 32'h0800_0000, 4'h8, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_CODE32_N, 32'h0C00_0000, 4'h8, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_CODE32_S, 32'h0A00_0000, 4'h8, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_CODE32_S, 32'h0A00_0000, 4'h8, 8'h00, 1'b0, 11'd0, 3'd0));
    // fetch outside the cartridge clears the credit
    send_access(bus_access(OP_DATA16_N, 32'h0000_0000, 4'h8, 8'hFF, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_CODE16_N, 32'h0E00_0000, 4'h8, 8'h00, 1'b0, 11'd0, 3'd0));
    // cartridge data access clears it as well
    send_access(bus_access(OP_DATA16_N, 32'h0000_0000, 4'h8, 8'hFF, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_DATA16_N, 32'h0900_0000, 4'h8, 8'h00, 1'b0, 11'd0, 3'd0));
    send_access(bus_access(OP_CODE16_N, 32'h0800_0000, 4'h8, 8'h00, 1'b0, 11'd0, 3'd0));
  endtask

  task automatic test_credit_floor();
    access_t a;
    drain();
    write_reg(CFG_ROM2_NONSEQ, 4'd0);
    write_reg(CFG_ROM2_SEQ, 4'd15);
    write_reg(CFG_PF_ENABLE, 4'd1);
    repeat (165) begin
      a = random_access();
      a.op = ($urandom_range(0, 1) == 0) ? OP_DATA16_N : OP_DATA32_S;
      a.addr[31:24] = 8'($urandom_range(0, 7));
      a.pc_region = 4'($urandom_range(12, 13));
      a.extra = 8'($urandom_range(0, 2));
      send_access(a);
    end
    repeat (4) begin
      a = random_access();
      a.op = 3'($urandom_range(OP_CODE16_N, OP_CODE32_S));
      a.addr[27:24] = 4'($urandom_range(8, 13));
      send_access(a);
    end
  endtask

  task automatic test_config_sweep();
    cfg_t setting;
    access_t a;
    int n;
    int len;
    int kind;
    logic [3:0] cart;
    bit paused;
    paused = 1'b0;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       setting = {{7{4'd0}}, 1'b1};
        1:       setting = {{7{4'd15}}, 1'b1};
        2:       setting = {{7{4'd8}}, 1'b0};
        3:       setting = 29'($urandom) | 29'd1;
        default: setting = 29'($urandom);
      endcase
      apply_setting(setting);
      n = 0;
      while (n < 55) begin
        if (phase == 1 && n >= 25 && !paused) begin
          drain();
          paused = 1'b1;
        end
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          // data accesses that build credit, then a run of cartridge fetches
          len = $urandom_range(1, 6);
          repeat (len) begin
            a = random_access();
            a.op = 3'($urandom_range(OP_DATA16_N, OP_DATA32_S));
            a.addr[31:24] = 8'($urandom_range(0, 7));
            if ($urandom_range(0, 1) != 0) a.pc_region = 4'($urandom_range(8, 13));
            send_access(a);
          end
          n += len;
          len = $urandom_range(1, 6);
          cart = 4'($urandom_range(8, 13));
          repeat (len) begin
            a = random_access();
            if ($urandom_range(0, 2) == 0) a.op = 3'($urandom_range(OP_CODE16_N, OP_CODE32_N));
            else a.op = 3'($urandom_range(OP_CODE16_S, OP_CODE32_S));
            a.addr[27:24] = cart;
            send_access(a);
          end
          n += len;
        end else if (kind < 7) begin
          a = random_access();
          a.op = OP_DATA32_N;
          a.addr[31:16] = 16'h0600;
          a.visible = ($urandom_range(0, 3) != 0);
          a.bg_mode = 3'($urandom_range(0, 3));
          a.line_cycle = 11'($urandom_range(0, 1100));
          send_access(a);
          n++;
        end else begin
          send_access(random_access());
          n++;
        end
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    logic [9:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_waits.size() == 0) begin
        $error("unexpected result item: wait_ticks %0d", out_tdata[9:0]);
        errors++;
      end else begin
        want = expected_waits.pop_front();
        if (out_tdata[9:0] !== want) begin
          $error("wait_ticks mismatch: expected %0d, actual %0d", want, out_tdata[9:0]);
          errors++;
        end
        results_checked++;
      end
    end
  end

  // receiver stall patterns, switched periodically at random
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 128 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ((rx_tick % 7) < 3);
      default: out_tready <= ((rx_tick % 32) >= 20);
    endcase
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    model_cfg = CFG_RESET;
    model_credit = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_fixed_regions();
    test_video_stall();
    test_prefetch_credit();
    test_credit_floor();
    test_config_sweep();
    drain();
    $display("summary: %0d accesses, %0d results checked, %0d register writes",
             items_sent, results_checked, cfg_writes);
    $display("summary: %0d video stalls, %0d credit spends, %0d credit floor clips",
             stall_hits, credit_spends, floor_hits);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[bus_wait_state_prefetch_timer.f]
sv/bwspt_pkg.sv
sv/bwspt_cfg_regs.sv
sv/bwspt_wait_table.sv
sv/bwspt_credit.sv
sv/bus_wait_state_prefetch_timer.sv
dv/tb.sv
